@@ src/rpn_pkg.sv @@
// Package for the RPN stack evaluator: token codes, status codes and default sizes.
`default_nettype none

package rpn_pkg;

  // Default stack geometry
  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Token kinds carried on the opcode port
  typedef enum logic [2:0] {
    OP_NUM = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_REM = 3'd5
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  // Control states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_DIV  = 4'b1000
  } fsm_t;

endpackage

`default_nettype wire

@@ src/rpn_stack_evaluator_core.sv @@
// RPN stack evaluator: value stack in a synchronous RAM with iterative multiply and divide.
// Timing: push, no-op, underflow and overflow tokens give their result in the cycle after
//   the start beat; add, subtract and division by zero pass through S_READ (one RAM read
//   of the left operand); multiply, divide and remainder then run the one-bit-per-cycle
//   shift loop in S_MUL or S_DIV. A token is taken only while busy is low (state S_IDLE).
// Reset: synchronous rst empties the stack (pointer to zero); RAM contents are not cleared.
// Results are strobed on done for one cycle; the receiver cannot stall.
`default_nettype none

module rpn_stack_evaluator_core
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [2:0]  opcode,
  input  wire logic signed [31:0] operand_value,
  output logic                    done,
  output logic signed [31:0]      top_value,
  output logic        [5:0]       stack_depth,
  output logic        [1:0]       status
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW  = $clog2(VALUE_WIDTH);
  localparam int W   = VALUE_WIDTH;

  typedef logic [W-1:0] value_t;

  // Stack RAM: entries below the pointer; the top is also kept in a register
  value_t           mem [STACK_DEPTH];
  value_t           rdata;
  logic   [AW-1:0]  raddr;
  logic             we;
  logic   [AW-1:0]  waddr;
  value_t           wdata;

  fsm_t             state;
  logic   [SPW-1:0] sp;
  value_t           top;
  opcode_t          op;
  value_t           acc;     // product accumulator or partial remainder
  value_t           shreg;   // multiplicand or dividend/quotient
  value_t           opnd;    // multiplier or divisor magnitude
  logic             neg_a;
  logic             neg_q;
  logic   [CW-1:0]  cnt;

  logic             accept;
  logic             full;
  value_t           vin;
  logic             last;
  logic             fin;
  value_t           r_fin;
  value_t           sh;
  logic   [W:0]     diff;
  value_t           q_new;
  value_t           rem_new;
  value_t           ma;
  value_t           mb;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (sp == SPW'(STACK_DEPTH));
  assign vin    = W'(operand_value);
  assign raddr  = AW'(sp - SPW'(2));
  assign last   = (cnt == CW'(W - 1));

  // Operand magnitudes for the divider
  assign ma = rdata[W-1] ? (~rdata + value_t'(1)) : rdata;
  assign mb = top[W-1]   ? (~top   + value_t'(1)) : top;

  // One restoring divide step
  assign sh      = {acc[W-2:0], shreg[W-1]};
  assign diff    = {1'b0, sh} - {1'b0, opnd};
  assign rem_new = diff[W] ? sh : diff[W-1:0];
  assign q_new   = {shreg[W-2:0], ~diff[W]};

  // Pick the finished result of an operator token
  always_comb begin
    fin   = 1'b0;
    r_fin = '0;
    case (state)
      S_READ: begin
        if (op == OP_ADD) begin
          fin   = 1'b1;
          r_fin = rdata + top;
        end else if (op == OP_SUB) begin
          fin   = 1'b1;
          r_fin = rdata - top;
        end
      end
      S_MUL: begin
        fin   = last;
        r_fin = acc + (opnd[0] ? shreg : '0);
      end
      S_DIV: begin
        fin = last;
        if (op == OP_DIV) begin
          r_fin = neg_q ? (~q_new + value_t'(1)) : q_new;
        end else begin
          r_fin = neg_a ? (~rem_new + value_t'(1)) : rem_new;
        end
      end
      default: begin
        fin   = 1'b0;
        r_fin = '0;
      end
    endcase
  end

  // Select the RAM write: a push, or the result over the left operand
  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = r_fin;
    if (accept && opcode == OP_NUM && !full) begin
      we    = 1'b1;
      waddr = sp[AW-1:0];
      wdata = vin;
    end else if (fin) begin
      we = 1'b1;
    end
  end

  // Stack RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Sequence tokens and drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= opcode_t'(opcode);
            if (opcode == OP_NUM) begin
              done        <= 1'b1;
              stack_depth <= 6'(sp);
              top_value   <= (sp == '0) ? 32'sd0 : 32'(signed'(top));
              status      <= ST_OVERFLOW;
              if (!full) begin
                sp          <= sp + SPW'(1);
                top         <= vin;
                stack_depth <= 6'(sp + SPW'(1));
                top_value   <= 32'(signed'(vin));
                status      <= ST_OK;
              end
            end else if (opcode > OP_REM || sp < SPW'(2)) begin
              // Hold the stack for no-op codes and underflow
              done        <= 1'b1;
              stack_depth <= 6'(sp);
              top_value   <= (sp == '0) ? 32'sd0 : 32'(signed'(top));
              status      <= (opcode > OP_REM) ? ST_OK : ST_UNDERFLOW;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          cnt <= '0;
          if (op == OP_MUL) begin
            acc   <= '0;
            shreg <= rdata;
            opnd  <= top;
            state <= S_MUL;
          end else if (op == OP_DIV || op == OP_REM) begin
            if (top == '0) begin
              done        <= 1'b1;
              stack_depth <= 6'(sp);
              top_value   <= 32'(signed'(top));
              status      <= ST_DIV_ZERO;
              state       <= S_IDLE;
            end else begin
              acc   <= '0;
              shreg <= ma;
              opnd  <= mb;
              neg_a <= rdata[W-1];
              neg_q <= rdata[W-1] ^ top[W-1];
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          cnt   <= cnt + CW'(1);
          acc   <= r_fin;
          shreg <= shreg << 1;
          opnd  <= opnd >> 1;
        end
        S_DIV: begin
          cnt   <= cnt + CW'(1);
          acc   <= rem_new;
          shreg <= q_new;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Retire an operator: drop one entry, new top is the result
      if (fin) begin
        sp          <= sp - SPW'(1);
        top         <= r_fin;
        done        <= 1'b1;
        stack_depth <= 6'(sp - SPW'(1));
        top_value   <= 32'(signed'(r_fin));
        status      <= ST_OK;
        state       <= S_IDLE;
      end
    end
  end

endmodule

`default_nettype wire
